@@ sv/fln_pkg.sv @@
// ----------------------------------------------------------------------------
// fln_pkg
// Shared types and constants of the fractal lattice noise block.
// ----------------------------------------------------------------------------
package fln_pkg;

  // Accumulator widths, sized for up to sixteen octaves
  localparam int SUM_W  = 56;
  localparam int NORM_W = 37;

  localparam logic [31:0] HASH_MUL_X = 32'd374761393;
  localparam logic [31:0] HASH_MUL_Y = 32'd668265263;
  localparam logic [31:0] HASH_MUL_M = 32'd1274126177;
  localparam logic [31:0] SEED_STEP  = 32'd1013;
  localparam logic [31:0] RIDGE_SEED = 32'd7919;
  localparam logic [31:0] AMP_ONE    = 32'd65536;

  // 1/sqrt(2) and sqrt(2) in Q.16
  localparam logic signed [17:0] DIAG_SCALE = 18'sd46341;
  localparam logic signed [17:0] GRAD_NORM  = 18'sd92682;

  // Constant term of the quintic fade polynomial, 10.0 in Q.16
  localparam logic [20:0] FADE_C10 = 21'd655360;

  typedef enum logic [2:0] {
    CFG_SEED_BASE    = 3'd0,
    CFG_BASE_FREQ    = 3'd1,
    CFG_FREQ_GAIN    = 3'd2,
    CFG_AMP_GAIN     = 3'd3,
    CFG_OCTAVE_COUNT = 3'd4,
    CFG_LATTICE_KIND = 3'd5
  } cfg_idx_t;

  // Settings each octave stage reads
  typedef struct packed {
    logic [23:0] freq_gain;
    logic [17:0] amp_gain;
    logic        lattice_kind;
  } oct_cfg_t;

  // Per-item state handed from octave to octave
  typedef struct packed {
    logic                    kind;
    logic signed [31:0]      cx;
    logic signed [31:0]      cy;
    logic [31:0]             seed0;
    logic [31:0]             freq;
    logic [31:0]             amp;
    logic [NORM_W-1:0]       norm;
    logic signed [SUM_W-1:0] sum;
  } octx_t;

endpackage

@@ sv/fln_ifs.sv @@
// ----------------------------------------------------------------------------
// fln channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface fln_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic [23:0]        freq_scale;
  logic [31:0]        seed_shift;

  modport source (output valid, kind, coord_x, coord_y, freq_scale, seed_shift,
                  input ready);
  modport sink   (input valid, kind, coord_x, coord_y, freq_scale, seed_shift,
                  output ready);
endinterface

interface fln_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] noise_out;

  modport source (output valid, noise_out, input ready);
  modport sink   (input valid, noise_out, output ready);
endinterface

interface fln_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/fractal_lattice_noise_2d.sv @@
// ----------------------------------------------------------------------------
// fractal_lattice_noise_2d
// Multi-octave 2D lattice noise (value or gradient), fractal or ridged sum.
// ----------------------------------------------------------------------------
// Takes one point per clock unless the output stalls, and returns one normalized
// Q3.13 noise value per point, in order. The datapath is a single pipeline: one
// entry stage, ten stages per octave (MAX_OCTAVES of them), one sign stage, an
// 18-stage restoring divider for the sum/amplitude-sum normalization and an
// output register. Octaves past octave_count still occupy their stages but add
// nothing. When the result is not taken the whole pipeline holds. Register
// writes are taken every cycle and must be made while no item is in flight.
// ----------------------------------------------------------------------------
module fractal_lattice_noise_2d import fln_pkg::*; #(
  parameter int MAX_OCTAVES     = 8,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  fln_in_if.sink    in_ch,
  fln_out_if.source out_ch,
  fln_cfg_if.sink   cfg_ch
);

  localparam int DIV_Q = 18;

  // ---------------- configuration registers
  logic [31:0] seed_base_r;
  logic [23:0] base_freq_r, freq_gain_r;
  logic [17:0] amp_gain_r;
  logic [3:0]  octave_count_r;
  logic        lattice_kind_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_base_r    <= '0;
      base_freq_r    <= 24'd65536;
      freq_gain_r    <= 24'd131072;
      amp_gain_r     <= 18'd32768;
      octave_count_r <= 4'd4;
      lattice_kind_r <= 1'b1;
    end else if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        CFG_SEED_BASE:    seed_base_r    <= cfg_ch.data;
        CFG_BASE_FREQ:    base_freq_r    <= cfg_ch.data[23:0];
        CFG_FREQ_GAIN:    freq_gain_r    <= cfg_ch.data[23:0];
        CFG_AMP_GAIN:     amp_gain_r     <= cfg_ch.data[17:0];
        CFG_OCTAVE_COUNT: octave_count_r <= cfg_ch.data[3:0];
        CFG_LATTICE_KIND: lattice_kind_r <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  logic [4:0]             n_oct;
  logic [MAX_OCTAVES-1:0] oct_en;
  oct_cfg_t               ocfg;

  always_comb begin
    n_oct = (octave_count_r > MAX_OCTAVES) ? 5'(MAX_OCTAVES) : {1'b0, octave_count_r};
    for (int k = 0; k < MAX_OCTAVES; k++) oct_en[k] = 5'(k) < n_oct;
    ocfg.freq_gain    = freq_gain_r;
    ocfg.amp_gain     = amp_gain_r;
    ocfg.lattice_kind = lattice_kind_r;
  end

  // ---------------- pipeline advance: hold everything while output stalls
  logic out_valid_r;
  logic adv;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // ---------------- entry stage
  logic [47:0] fs_prod;
  logic        f0_v_r;
  octx_t       f0_ctx_r;

  assign fs_prod = base_freq_r * in_ch.freq_scale;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f0_v_r <= 1'b0;
    end else if (adv) begin
      f0_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f0_ctx_r.kind  <= in_ch.kind;
      f0_ctx_r.cx    <= in_ch.coord_x;
      f0_ctx_r.cy    <= in_ch.coord_y;
      f0_ctx_r.seed0 <= seed_base_r + (in_ch.kind ? RIDGE_SEED : in_ch.seed_shift);
      f0_ctx_r.freq  <= in_ch.kind ? {8'h00, base_freq_r} : fs_prod[47:16];
      f0_ctx_r.amp   <= AMP_ONE;
      f0_ctx_r.norm  <= '0;
      f0_ctx_r.sum   <= '0;
    end
  end

  // ---------------- octave chain
  logic  chv [0:MAX_OCTAVES];
  octx_t ch  [0:MAX_OCTAVES];

  assign chv[0] = f0_v_r;
  assign ch[0]  = f0_ctx_r;

  generate
    for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
      fln_octave #(
        .OCT_IDX         (k),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
      ) u_oct (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .en        (oct_en[k]),
        .cfg       (ocfg),
        .in_valid  (chv[k]),
        .in_ctx    (ch[k]),
        .out_valid (chv[k+1]),
        .out_ctx   (ch[k+1])
      );
    end
  endgenerate

  // ---------------- normalization: |sum| / norm, one quotient bit per stage
  // The weighted mean stays below 2^17 in magnitude, so 18 bits suffice.
  logic [DIV_Q:0]    dv_v_r;
  logic [SUM_W-1:0]  dv_rem_r  [0:DIV_Q];
  logic [NORM_W-1:0] dv_norm_r [0:DIV_Q];
  logic [DIV_Q-1:0]  dv_q_r    [0:DIV_Q];
  logic              dv_neg_r  [0:DIV_Q];
  logic [SUM_W-1:0]  rem_nxt   [DIV_Q];
  logic              ge        [DIV_Q];
  logic signed [SUM_W-1:0] sum_fin;

  assign sum_fin = ch[MAX_OCTAVES].sum;

  always_comb begin
    for (int j = 0; j < DIV_Q; j++) begin
      logic [SUM_W-1:0] sh;
      sh = SUM_W'(dv_norm_r[j]) << (DIV_Q - 1 - j);
      ge[j]      = dv_rem_r[j] >= sh;
      rem_nxt[j] = ge[j] ? dv_rem_r[j] - sh : dv_rem_r[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r <= '0;
    end else if (adv) begin
      dv_v_r <= {dv_v_r[DIV_Q-1:0], chv[MAX_OCTAVES]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_rem_r[0]  <= sum_fin[SUM_W-1] ? SUM_W'(-sum_fin) : SUM_W'(sum_fin);
      dv_norm_r[0] <= ch[MAX_OCTAVES].norm;
      dv_q_r[0]    <= '0;
      dv_neg_r[0]  <= sum_fin[SUM_W-1];
      for (int j = 0; j < DIV_Q; j++) begin
        dv_rem_r[j+1]  <= rem_nxt[j];
        dv_norm_r[j+1] <= dv_norm_r[j];
        dv_q_r[j+1]    <= {dv_q_r[j][DIV_Q-2:0], ge[j]};
        dv_neg_r[j+1]  <= dv_neg_r[j];
      end
    end
  end

  // ---------------- output register
  logic signed [DIV_Q:0] q_signed;
  logic signed [15:0]    noise_r;

  assign q_signed = dv_neg_r[DIV_Q] ? -$signed({1'b0, dv_q_r[DIV_Q]})
                                    :  $signed({1'b0, dv_q_r[DIV_Q]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_v_r[DIV_Q];
    end
  end

  // floor by three bits; a zero amplitude sum means no octaves
  always_ff @(posedge clk) begin
    if (adv) begin
      noise_r <= (dv_norm_r[DIV_Q] == '0) ? 16'sd0 : q_signed[DIV_Q:3];
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.noise_out = noise_r;

endmodule

@@ sv/fln_octave.sv @@
// ----------------------------------------------------------------------------
// fln_octave
// Ten-stage pipeline for one octave: scale, hash, fade, corner values,
// bilinear blend, ridge shaping and weighted accumulation.
// ----------------------------------------------------------------------------
module fln_octave import fln_pkg::*; #(
  parameter int OCT_IDX         = 0,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     adv,
  input  logic     en,
  input  oct_cfg_t cfg,
  input  logic     in_valid,
  input  octx_t    in_ctx,
  output logic     out_valid,
  output octx_t    out_ctx
);

  localparam int          STG    = 10;
  localparam int          EXT_W  = 65 + COORD_FRAC_BITS;
  localparam logic [31:0] SEED_K = 32'(OCT_IDX * 1013);

  function automatic logic signed [19:0] grad_dot(input logic [2:0] hc,
                                                  input logic signed [17:0] dx,
                                                  input logic signed [17:0] dy);
    logic signed [18:0] sx, sy, s, st;
    logic signed [36:0] p;
    sx = {dx[17], dx};
    sy = {dy[17], dy};
    // diagonal: x negated when bit2^bit1, y negated when bit2
    s  = ((hc[2] ^ hc[1]) ? -sx : sx) + (hc[2] ? -sy : sy);
    st = hc[1] ? sy : sx;
    st = hc[2] ? -st : st;
    p  = s * DIAG_SCALE;
    return hc[0] ? p[35:16] : {st[18], st};
  endfunction

  function automatic logic signed [21:0] lerp16(input logic signed [21:0] a,
                                                input logic signed [21:0] b,
                                                input logic [16:0] t);
    logic signed [22:0] d;
    logic signed [40:0] p;
    d = {b[21], b} - {a[21], a};
    p = d * $signed({1'b0, t});
    return a + $signed(p[37:16]);
  endfunction

  logic [STG:1] v_r;
  octx_t        ctx_r [1:STG];

  // ---------------- stage 1: scale point, next frequency
  logic signed [64:0] px_full, py_full;
  logic [55:0]        fq_prod;
  octx_t              c1_nxt;
  logic signed [64:0] px1_r, py1_r;
  logic [31:0]        seed1_r;

  always_comb begin
    px_full = in_ctx.cx * $signed({1'b0, in_ctx.freq});
    py_full = in_ctx.cy * $signed({1'b0, in_ctx.freq});
    fq_prod = in_ctx.freq * cfg.freq_gain;
    c1_nxt  = in_ctx;
    c1_nxt.freq = (|fq_prod[55:48]) ? 32'hFFFF_FFFF : fq_prod[47:16];
  end

  // ---------------- stage 2: cell, fraction, hash products, t^2
  logic [EXT_W-1:0] ext_x, ext_y;
  logic [31:0]      x0, y0;
  logic [15:0]      fx, fy;
  logic [31:0]      sqx, sqy;
  logic [31:0]      xa2_r, ya2_r, seed2_r;
  logic [15:0]      fx2_r, fy2_r, t2x2_r, t2y2_r;

  assign ext_x = {{COORD_FRAC_BITS{px1_r[64]}}, px1_r};
  assign ext_y = {{COORD_FRAC_BITS{py1_r[64]}}, py1_r};
  assign x0    = ext_x[16+COORD_FRAC_BITS +: 32];
  assign y0    = ext_y[16+COORD_FRAC_BITS +: 32];

  generate
    if (COORD_FRAC_BITS >= 16) begin : g_frac_drop
      assign fx = ext_x[COORD_FRAC_BITS +: 16];
      assign fy = ext_y[COORD_FRAC_BITS +: 16];
    end else begin : g_frac_pad
      assign fx = {ext_x[16 +: COORD_FRAC_BITS], {(16-COORD_FRAC_BITS){1'b0}}};
      assign fy = {ext_y[16 +: COORD_FRAC_BITS], {(16-COORD_FRAC_BITS){1'b0}}};
    end
  endgenerate

  assign sqx = fx * fx;
  assign sqy = fy * fy;

  // ---------------- stage 3: corner hash mix, t^3, fade polynomial
  logic [31:0] g3_nxt [4];
  logic [31:0] g3_r   [4];
  logic [31:0] cbx, cby;
  logic [20:0] polyx, polyy;
  logic [15:0] t3x, t3y, fx3_r, fy3_r, t3x3_r, t3y3_r;
  logic [20:0] polyx3_r, polyy3_r;

  always_comb begin
    cbx = t2x2_r * fx2_r;
    cby = t2y2_r * fy2_r;
    t3x = cbx[31:16];
    t3y = cby[31:16];
    polyx = 21'(t2x2_r) * 21'd6 + FADE_C10 - 21'(fx2_r) * 21'd15;
    polyy = 21'(t2y2_r) * 21'd6 + FADE_C10 - 21'(fy2_r) * 21'd15;
    for (int c = 0; c < 4; c++) begin
      logic [31:0] xs, ys, h;
      xs = c[0] ? xa2_r + HASH_MUL_X : xa2_r;
      ys = c[1] ? ya2_r + HASH_MUL_Y : ya2_r;
      h  = seed2_r ^ xs ^ ys;
      g3_nxt[c] = h ^ (h >> 13);
    end
  end

  // ---------------- stage 4: hash multiply, fade
  logic [31:0] hm4_r [4];
  logic [36:0] fpx, fpy;
  logic [16:0] fadex4_r, fadey4_r;
  logic [15:0] fx4_r, fy4_r;

  assign fpx = t3x3_r * polyx3_r;
  assign fpy = t3y3_r * polyy3_r;

  // ---------------- stage 5: corner values
  logic signed [19:0] crn_nxt [4];
  logic signed [19:0] crn5_r  [4];
  logic [16:0]        fadex5_r, fadey5_r;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      logic [31:0]        hs;
      logic signed [17:0] dx, dy, vc;
      hs = hm4_r[c] ^ (hm4_r[c] >> 16);
      dx = c[0] ? $signed({2'b00, fx4_r}) - 18'sd65536 : $signed({2'b00, fx4_r});
      dy = c[1] ? $signed({2'b00, fy4_r}) - 18'sd65536 : $signed({2'b00, fy4_r});
      vc = $signed({1'b0, hs[15:0], 1'b0}) - 18'sd65535;
      crn_nxt[c] = cfg.lattice_kind ? grad_dot(hs[2:0], dx, dy) : 20'(vc);
    end
  end

  // ---------------- stages 6..8: blend along x, along y, gradient scale
  logic signed [21:0] ab6_r, cd6_r, v7_r;
  logic [16:0]        fadey6_r;
  logic signed [39:0] p8;
  logic signed [19:0] n8_r;

  assign p8 = v7_r * GRAD_NORM;

  // ---------------- stage 9: ridge shaping
  logic signed [19:0] absn, rr_base, t9_r;
  logic signed [39:0] rsq;

  always_comb begin
    absn    = n8_r[19] ? -n8_r : n8_r;
    rr_base = 20'sd65536 - absn;
    rsq     = rr_base * rr_base;
  end

  // ---------------- stage 10: weight and accumulate
  logic signed [52:0] term;
  logic [49:0]        amp_prod;
  octx_t              c10_nxt;

  always_comb begin
    term     = t9_r * $signed({1'b0, ctx_r[9].amp});
    amp_prod = ctx_r[9].amp * cfg.amp_gain;
    c10_nxt  = ctx_r[9];
    c10_nxt.amp = (|amp_prod[49:48]) ? 32'hFFFF_FFFF : amp_prod[47:16];
    if (en) begin
      c10_nxt.sum  = ctx_r[9].sum + {{(SUM_W-53){term[52]}}, term};
      c10_nxt.norm = ctx_r[9].norm + NORM_W'(ctx_r[9].amp);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[STG-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx_r[1] <= c1_nxt;
      for (int s = 2; s < STG; s++) ctx_r[s] <= ctx_r[s-1];
      ctx_r[STG] <= c10_nxt;

      px1_r   <= px_full;
      py1_r   <= py_full;
      seed1_r <= in_ctx.seed0 + SEED_K;

      xa2_r   <= x0 * HASH_MUL_X;
      ya2_r   <= y0 * HASH_MUL_Y;
      seed2_r <= seed1_r;
      fx2_r   <= fx;
      fy2_r   <= fy;
      t2x2_r  <= sqx[31:16];
      t2y2_r  <= sqy[31:16];

      g3_r     <= g3_nxt;
      fx3_r    <= fx2_r;
      fy3_r    <= fy2_r;
      t3x3_r   <= t3x;
      t3y3_r   <= t3y;
      polyx3_r <= polyx;
      polyy3_r <= polyy;

      for (int c = 0; c < 4; c++) hm4_r[c] <= g3_r[c] * HASH_MUL_M;
      fadex4_r <= fpx[32:16];
      fadey4_r <= fpy[32:16];
      fx4_r    <= fx3_r;
      fy4_r    <= fy3_r;

      crn5_r   <= crn_nxt;
      fadex5_r <= fadex4_r;
      fadey5_r <= fadey4_r;

      ab6_r    <= lerp16(22'(crn5_r[0]), 22'(crn5_r[1]), fadex5_r);
      cd6_r    <= lerp16(22'(crn5_r[2]), 22'(crn5_r[3]), fadex5_r);
      fadey6_r <= fadey5_r;

      v7_r <= lerp16(ab6_r, cd6_r, fadey6_r);

      n8_r <= cfg.lattice_kind ? p8[35:16] : v7_r[19:0];

      t9_r <= ctx_r[8].kind ? $signed({3'b000, rsq[32:16]}) : n8_r;
    end
  end

  assign out_valid = v_r[STG];
  assign out_ctx   = ctx_r[STG];

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for fractal_lattice_noise_2d. Points go in on the input
// channel, a bit-accurate octave-sum model predicts each noise value, and
// every result is checked in order. Register settings change between phases
// while the pipeline is empty; both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb import fln_pkg::*; ();

  localparam int  LATENCY   = 10 * 8 + 21;
  localparam int  CYC_LIMIT = 600000;

  logic clk;
  logic rst_n;

  fln_in_if  in_if();
  fln_out_if out_if();
  fln_cfg_if cfg_if();

  fractal_lattice_noise_2d dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Register copies held by the noise model
  logic [31:0] m_seed_base;
  logic [23:0] m_base_freq;
  logic [23:0] m_freq_gain;
  logic [17:0] m_amp_gain;
  logic [3:0]  m_octaves;
  logic        m_lattice;

  logic signed [15:0] noise_q[$];
  int unsigned        err_cnt;
  int unsigned        cyc_cnt;
  int unsigned        hold_off;   // long receiver hold-off, in cycles
  bit                 quiet;      // no idling on either side

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt > CYC_LIMIT) begin
      $display("[fractal_lattice_noise_2d] ERROR");
      $finish;
    end
  end

  // ---------------- noise model ----------------
  function automatic logic [31:0] corner_hash(logic [31:0] x, logic [31:0] y,
                                              logic [31:0] seed);
    logic [31:0] h;
    h = seed ^ (x * HASH_MUL_X) ^ (y * HASH_MUL_Y);
    h = (h ^ (h >> 13)) * HASH_MUL_M;
    return h ^ (h >> 16);
  endfunction

  function automatic longint quintic_fade(longint t);
    longint t2, t3;
    t2 = (t * t) >>> 16;
    t3 = (t2 * t) >>> 16;
    return (t3 * (6 * t2 - 15 * t + 10 * 65536)) >>> 16;
  endfunction

  function automatic longint blend(longint a, longint b, longint t);
    return a + (((b - a) * t) >>> 16);
  endfunction

  function automatic longint grad_dot(logic [31:0] h, longint dx, longint dy);
    case (h[2:0])
      3'd0: return dx;
      3'd1: return ((dx + dy) * 46341) >>> 16;
      3'd2: return dy;
      3'd3: return ((dy - dx) * 46341) >>> 16;
      3'd4: return -dx;
      3'd5: return ((-dx - dy) * 46341) >>> 16;
      3'd6: return -dy;
      default: return ((dx - dy) * 46341) >>> 16;
    endcase
  endfunction

  function automatic longint lattice_sample(longint px, longint py, logic [31:0] seed);
    logic [31:0] x0, y0, x1, y1;
    longint xf, yf, tx, ty, a, b, c, d;
    x0 = 32'(px >>> 16);
    y0 = 32'(py >>> 16);
    xf = px & 64'hffff;
    yf = py & 64'hffff;
    x1 = x0 + 32'd1;
    y1 = y0 + 32'd1;
    tx = quintic_fade(xf);
    ty = quintic_fade(yf);
    if (m_lattice) begin
      a = grad_dot(corner_hash(x0, y0, seed), xf, yf);
      b = grad_dot(corner_hash(x1, y0, seed), xf - 65536, yf);
      c = grad_dot(corner_hash(x0, y1, seed), xf, yf - 65536);
      d = grad_dot(corner_hash(x1, y1, seed), xf - 65536, yf - 65536);
      return (blend(blend(a, b, tx), blend(c, d, tx), ty) * 92682) >>> 16;
    end
    a = 2 * longint'(corner_hash(x0, y0, seed) & 32'hffff) - 65535;
    b = 2 * longint'(corner_hash(x1, y0, seed) & 32'hffff) - 65535;
    c = 2 * longint'(corner_hash(x0, y1, seed) & 32'hffff) - 65535;
    d = 2 * longint'(corner_hash(x1, y1, seed) & 32'hffff) - 65535;
    return blend(blend(a, b, tx), blend(c, d, tx), ty);
  endfunction

  function automatic longint clamp_u32(longint v);
    return (v > 64'hffffffff) ? 64'hffffffff : v;
  endfunction

  function automatic logic signed [15:0] predict_noise(logic kind,
      logic signed [31:0] cx, logic signed [31:0] cy, logic [23:0] fscale,
      logic [31:0] shift);
    int unsigned n_oct;
    longint freq, amp, norm, sum, n, r, q;
    logic [31:0] sh, seed;
    n_oct = (m_octaves > 8) ? 8 : m_octaves;
    amp = 65536;
    norm = 0;
    sum = 0;
    sh = shift;
    if (kind) begin
      freq = m_base_freq;
      sh = RIDGE_SEED;
    end else begin
      freq = clamp_u32((longint'(m_base_freq) * longint'(fscale)) >>> 16);
    end
    if (n_oct == 0) return 16'sd0;
    for (int k = 0; k < n_oct; k++) begin
      seed = m_seed_base + sh + 32'(k) * SEED_STEP;
      n = lattice_sample((longint'(cx) * freq) >>> 16, (longint'(cy) * freq) >>> 16, seed);
      if (kind) begin
        r = 65536 - ((n < 0) ? -n : n);
        sum += ((r * r) >>> 16) * amp;
      end else begin
        sum += n * amp;
      end
      norm += amp;
      freq = clamp_u32((freq * longint'(m_freq_gain)) >>> 16);
      amp = clamp_u32((amp * longint'(m_amp_gain)) >>> 16);
    end
    q = (sum / norm) >>> 3;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return 16'(q);
  endfunction

  // ---------------- result side ----------------
  always @(posedge clk) begin
    logic signed [15:0] want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (noise_q.size() == 0) begin
        $display("%0t: unexpected result noise_out=%0d", $time, out_if.noise_out);
        err_cnt++;
      end else begin
        want = noise_q.pop_front();
        if (out_if.noise_out !== want) begin
          $display("%0t: noise_out mismatch expected=%0d actual=%0d",
                   $time, want, out_if.noise_out);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    int unsigned n;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_if.ready <= 1'b0;
        hold_off--;
      end else if (quiet || $urandom_range(0, 3) != 0) begin
        out_if.ready <= 1'b1;
      end else begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
        out_if.ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  // ---------------- input side ----------------
  // Called at a falling edge; returns at a falling edge with valid still high
  task automatic send_point(logic kind, logic signed [31:0] cx, logic signed [31:0] cy,
                            logic [23:0] fscale, logic [31:0] shift);
    in_if.valid      <= 1'b1;
    in_if.kind       <= kind;
    in_if.coord_x    <= cx;
    in_if.coord_y    <= cy;
    in_if.freq_scale <= fscale;
    in_if.seed_shift <= shift;
    do @(posedge clk); while (!in_if.ready);
    noise_q = {noise_q, predict_noise(kind, cx, cy, fscale, shift)};
    @(negedge clk);
  endtask

  task automatic pause_input(int unsigned n);
    in_if.valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic random_gap();
    if (!quiet && $urandom_range(0, 2) == 0)
      pause_input(($urandom_range(0, 14) == 0) ? $urandom_range(15, 50)
                                                 : $urandom_range(1, 3));
  endtask

  task automatic drain();
    pause_input(1);
    while (noise_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      CFG_SEED_BASE:    m_seed_base = data;
      CFG_BASE_FREQ:    m_base_freq = data[23:0];
      CFG_FREQ_GAIN:    m_freq_gain = data[23:0];
      CFG_AMP_GAIN:     m_amp_gain  = data[17:0];
      CFG_OCTAVE_COUNT: m_octaves   = data[3:0];
      CFG_LATTICE_KIND: m_lattice   = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_all(logic [31:0] sb, logic [23:0] bf, logic [23:0] fg,
                         logic [17:0] ag, logic [3:0] oc, logic lk);
    write_reg(CFG_SEED_BASE, sb);
    write_reg(CFG_BASE_FREQ, {8'd0, bf});
    write_reg(CFG_FREQ_GAIN, {8'd0, fg});
    write_reg(CFG_AMP_GAIN, {14'd0, ag});
    write_reg(CFG_OCTAVE_COUNT, {28'd0, oc});
    write_reg(CFG_LATTICE_KIND, {31'd0, lk});
  endtask

  // Mostly small coordinates and unit-ish frequency scales, some full range
  task automatic send_random();
    logic signed [31:0] cx, cy;
    logic [23:0] fs;
    if ($urandom_range(0, 3) == 0) begin
      cx = $urandom;
      cy = $urandom;
      fs = 24'($urandom);
    end else begin
      cx = $signed($urandom_range(0, 32'h00ffffff)) - 32'sh0080_0000;
      cy = $signed($urandom_range(0, 32'h00ffffff)) - 32'sh0080_0000;
      fs = 24'($urandom_range(0, 24'h03ffff));
    end
    send_point(1'($urandom_range(0, 1)), cx, cy, fs, $urandom);
    random_gap();
  endtask

  // ---------------- tests ----------------
  task automatic test_directed();
    set_all(32'd0, 24'd65536, 24'd131072, 18'd32768, 4'd4, 1'b1);
    send_point(1'b0, 32'sd0, 32'sd0, 24'd65536, 32'd0);
    send_point(1'b0, 32'sh7fffffff, 32'sh7fffffff, 24'hffffff, 32'hffffffff);
    send_point(1'b0, -32'sh80000000, -32'sh80000000, 24'hffffff, 32'd0);
    send_point(1'b1, -32'sd1, 32'sh0001_8000, 24'd0, 32'h1234_5678);
    send_point(1'b0, 32'sh0003_4000, -32'sh0002_c000, 24'd0, 32'd7);
    send_point(1'b1, 32'sh7fffffff, -32'sh80000000, 24'hffffff, 32'hffffffff);
    // value noise, then zero octaves, then a count beyond the stage count
    write_reg(CFG_LATTICE_KIND, 32'd0);
    send_point(1'b0, 32'sh0001_2345, 32'sh0006_789a, 24'd65536, 32'd99);
    send_point(1'b1, 32'sh0001_2345, 32'sh0006_789a, 24'd65536, 32'd99);
    send_point(1'b0, 32'sh7fffffff, -32'sh80000000, 24'hffffff, 32'hffffffff);
    write_reg(CFG_OCTAVE_COUNT, 32'd0);
    send_point(1'b0, 32'sh0001_0000, 32'sh0002_0000, 24'd65536, 32'd0);
    send_point(1'b1, 32'sh0001_0000, 32'sh0002_0000, 24'd65536, 32'd0);
    write_reg(CFG_OCTAVE_COUNT, 32'd15);
    send_point(1'b0, 32'sh0004_1000, 32'sh0003_9000, 24'd65536, 32'd5);
    send_point(1'b1, 32'sh0004_1000, 32'sh0003_9000, 24'd65536, 32'd5);
    write_reg(CFG_LATTICE_KIND, 32'd1);
    send_point(1'b0, 32'sh0004_1000, 32'sh0003_9000, 24'd65536, 32'd5);
    // saturating frequency and amplitude, far cells wrap
    set_all(32'hffffffff, 24'hffffff, 24'hffffff, 18'h3ffff, 4'd8, 1'b1);
    send_point(1'b0, 32'sh7fffffff, 32'sh1234_5678, 24'hffffff, 32'hffffffff);
    send_point(1'b1, -32'sh7fff_0000, 32'sh0000_ffff, 24'd1, 32'd0);
    write_reg(CFG_LATTICE_KIND, 32'd0);
    send_point(1'b0, -32'sh0123_4567, 32'sh7654_3210, 24'h00ffff, 32'h8000_0000);
    send_point(1'b1, 32'sh0000_8000, -32'sh0000_8000, 24'd0, 32'd0);
    drain();
  endtask

  task automatic test_random_settings();
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: set_all(32'd0, 24'd65536, 24'd131072, 18'd32768, 4'd4, 1'b1);
        1: set_all(32'hffffffff, 24'd0, 24'd0, 18'd0, 4'd8, 1'b0);
        2: set_all($urandom, 24'hffffff, 24'hffffff, 18'd131072, 4'd1, 1'b1);
        3: set_all($urandom, 24'd65536, 24'd65536, 18'h3ffff, 4'd15, 1'b0);
        default: set_all($urandom, 24'($urandom_range(0, 24'h04_0000)),
                         24'($urandom_range(0, 24'h04_0000)),
                         18'($urandom_range(0, 131072)),
                         4'($urandom_range(0, 9)), 1'($urandom_range(0, 1)));
      endcase
      quiet = (ph == 5);
      repeat (100) send_random();
    end
    quiet = 1'b0;
    drain();
  endtask

  task automatic test_backpressure();
    set_all($urandom, 24'd98304, 24'd131072, 18'd40000, 4'd8, 1'b1);
    hold_off = 300;
    repeat (150) send_point(1'($urandom_range(0, 1)), $urandom, $urandom,
                            24'($urandom_range(0, 24'h02ffff)), $urandom);
    drain();
  endtask

  task automatic test_drain_pause();
    set_all($urandom, 24'd65536, 24'd120000, 18'd32768, 4'd5, 1'b0);
    repeat (40) send_random();
    drain();
    repeat (40) send_random();
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    err_cnt = 0;
    cyc_cnt = 0;
    hold_off = 0;
    quiet = 1'b0;
    in_if.valid = 1'b0;
    in_if.kind = 1'b0;
    in_if.coord_x = '0;
    in_if.coord_y = '0;
    in_if.freq_scale = '0;
    in_if.seed_shift = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_SEED_BASE;
    cfg_if.data = '0;
    m_seed_base = 32'd0;
    m_base_freq = 24'd65536;
    m_freq_gain = 24'd131072;
    m_amp_gain = 18'd32768;
    m_octaves = 4'd4;
    m_lattice = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random_settings();
    test_backpressure();
    test_drain_pause();

    drain();
    repeat (LATENCY + 20) @(posedge clk);
    if (err_cnt == 0 && noise_q.size() == 0) begin
      $display("[fractal_lattice_noise_2d] OK");
    end else begin
      $display("[fractal_lattice_noise_2d] ERROR");
    end
    $finish;
  end

endmodule
